// File: rtl/core/rexr_pkg.sv
// rexr_pkg: shared constants, types and the 2^-f table for the replica exchange block
// no dependencies; imported by rexr_if, rexr_front, rexr_back and the top
package rexr_pkg;

    localparam int MAX_REPLICAS_DEF = 16;

    localparam int ENERGY_W   = 32;
    localparam int BETA_W     = 32;
    localparam int RAND_W     = 16;
    localparam int OUT_SLOT_W = 4;
    localparam int COUNT_W    = 32;

    // log2(e) in q.16 and 2^(-1/256) in q.32
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [31:0] STEP_Q32  = 32'd4283353945;

    // 2^-f table, f in 1/256 steps, scaled to 16 bits
    typedef logic [15:0] t_exp_table [256];

    function automatic t_exp_table build_exp_table();
        t_exp_table tbl;
        logic [64:0] v;
        logic [64:0] t;
        v = 65'd1 << 32;
        for (int i = 0; i < 256; i++) begin
            t = (v + 65'd32768) >> 16;
            tbl[i] = (t > 65'd65535) ? 16'hFFFF : t[15:0];
            v = (v * {33'd0, STEP_Q32} + 65'd2147483648) >> 32;
        end
        return tbl;
    endfunction

    localparam t_exp_table EXP_TABLE = build_exp_table();

    // differences of one pair, handed from front to back
    typedef struct packed {
        logic signed [ENERGY_W:0] d_energy;
        logic signed [BETA_W:0]   d_beta;
        logic [RAND_W-1:0]        rand_u16;
    } t_pair_calc;

endpackage

// File: rtl/core/rexr_if.sv
// rexr_if: request and result channel interfaces of the replica exchange block
// depends on rexr_pkg for field widths
interface rexr_req_if import rexr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
    logic [BETA_W-1:0]   inv_temp;
    logic [RAND_W-1:0]   rand_u16;
    logic                last_in_round;

    modport source (output valid, energy, inv_temp, rand_u16, last_in_round, input ready);
    modport sink   (input valid, energy, inv_temp, rand_u16, last_in_round, output ready);
endinterface

interface rexr_res_if import rexr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OUT_SLOT_W-1:0] lower_slot;
    logic                  accepted;
    logic [OUT_SLOT_W-1:0] lower_origin;
    logic [OUT_SLOT_W-1:0] upper_origin;
    logic [COUNT_W-1:0]    accept_count;

    modport source (output valid, lower_slot, accepted, lower_origin, upper_origin,
                    accept_count, input ready);
    modport sink   (input valid, lower_slot, accepted, lower_origin, upper_origin,
                    accept_count, output ready);
endinterface

// File: rtl/core/rexr_ram.sv
// rexr_ram: generic single write port, single read port ram with registered read
// no dependencies
module rexr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/rexr_front.sv
// rexr_front: slot tracking, pairing and differences of each accepted request
// depends on rexr_pkg and rexr_if
module rexr_front import rexr_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rexr_req_if.sink                        i_req,
    input  logic                            i_full,
    output logic                            o_push,
    output logic [$clog2(MAX_REPLICAS)-1:0] o_push_lo,
    output t_pair_calc                      o_push_calc
);

    localparam int IW = $clog2(MAX_REPLICAS);
    localparam int SW = $clog2(MAX_REPLICAS + 1);

    logic [SW-1:0]       r_slot, n_slot;
    logic                r_parity, n_parity;
    logic [ENERGY_W-1:0] r_prev_e;
    logic [BETA_W-1:0]   r_prev_b;
    logic                accept, in_range, is_upper;
    logic [SW-1:0]       lo_full;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;

    assign in_range = r_slot < SW'(MAX_REPLICAS);
    // upper slot when the lower slot (s-1) has the parity of the round
    assign is_upper = in_range && (r_slot != '0) && ((!r_slot[0]) == r_parity);
    assign lo_full  = r_slot - SW'(1);

    assign o_push                = accept && is_upper;
    assign o_push_lo             = lo_full[IW-1:0];
    assign o_push_calc.d_energy  = $signed({r_prev_e[ENERGY_W-1], r_prev_e})
                                 - $signed({i_req.energy[ENERGY_W-1], i_req.energy});
    assign o_push_calc.d_beta    = $signed({1'b0, i_req.inv_temp}) - $signed({1'b0, r_prev_b});
    assign o_push_calc.rand_u16  = i_req.rand_u16;

    always_comb begin
        n_slot   = r_slot;
        n_parity = r_parity;
        if (accept) begin
            if (in_range) begin
                n_slot = r_slot + SW'(1);
            end
            if (i_req.last_in_round) begin
                n_slot   = '0;
                n_parity = !r_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_parity <= 1'b0;
            r_prev_e <= '0;
            r_prev_b <= '0;
        end else begin
            r_slot   <= n_slot;
            r_parity <= n_parity;
            if (accept && in_range) begin
                r_prev_e <= i_req.energy;
                r_prev_b <= i_req.inv_temp;
            end
        end
    end

`ifndef SYNTHESIS
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SW'(MAX_REPLICAS))
        else $error("slot counter past replica count");
`endif

endmodule

// File: rtl/core/rexr_fifo.sv
// rexr_fifo: short queue of pair requests between front and back
// no dependencies
module rexr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
`endif

endmodule

// File: rtl/core/rexr_back.sv
// rexr_back: exchange decision sequencer, origin and counter memories, result register
// depends on rexr_pkg, rexr_if and rexr_ram
module rexr_back import rexr_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  logic [$clog2(MAX_REPLICAS)-1:0] i_lo,
    input  t_pair_calc                      i_calc,
    output logic                            o_pop,
    rexr_res_if.source                      o_res
);

    localparam int IW = $clog2(MAX_REPLICAS);

    typedef enum logic [2:0] {
        S_IDLE, S_ABS, S_MUL, S_EXP, S_DEC, S_WR2
    } t_state;

    t_state              r_state;
    logic [IW-1:0]       r_lo, hi;
    t_pair_calc          r_calc;
    logic [ENERGY_W-1:0] r_mag_e;
    logic [BETA_W-1:0]   r_mag_b;
    logic                r_quick;
    logic [63:0]         r_prod;
    logic [32:0]         r_x;
    logic                r_big;
    logic [IW-1:0]       r_org_lo, r_org_hi;
    logic [COUNT_W-1:0]  r_cnt;
    logic [MAX_REPLICAS-1:0] r_org_vld, r_cnt_vld;

    logic [IW-1:0]      org_raddr, org_waddr, org_wdata, org_rdata;
    logic               org_we, cnt_we;
    logic [COUNT_W-1:0] cnt_rdata, cnt_next;
    logic [48:0]        x_full;
    logic [16:0]        n_int;
    logic [15:0]        prob;
    logic               hit, acc, out_free, fire;
    logic [ENERGY_W:0]  neg_e;
    logic [BETA_W:0]    neg_b;
    logic [IW+3:0]      lo_ext, olo_ext, ohi_ext;

    assign hi       = r_lo + IW'(1);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !o_res.valid || o_res.ready;
    assign fire     = (r_state == S_DEC) && out_free;

    assign neg_e = -r_calc.d_energy;
    assign neg_b = -r_calc.d_beta;

    // second step of exp: delta * log2(e), q.16
    assign x_full = 49'(r_prod[49:18]) * 49'(LOG2E_Q16);

    // probability from the table, shifted by the integer part
    assign n_int = r_x[32:16];
    assign prob  = EXP_TABLE[r_x[15:8]] >> n_int[3:0];
    assign hit   = !r_big && (n_int < 17'd16) && (prob > r_calc.rand_u16);
    assign acc   = r_quick || hit;

    assign cnt_next = (acc && (r_cnt != '1)) ? r_cnt + COUNT_W'(1) : r_cnt;

    // origin memory: read lower then upper, write lower then upper on a swap
    assign org_raddr = (r_state == S_IDLE) ? i_lo : hi;
    assign org_we    = (fire && acc) || (r_state == S_WR2);
    assign org_waddr = (r_state == S_WR2) ? hi : r_lo;
    assign org_wdata = (r_state == S_WR2) ? r_org_lo : r_org_hi;
    assign cnt_we    = fire && acc;

    assign lo_ext  = {4'd0, r_lo};
    assign olo_ext = {4'd0, (acc ? r_org_hi : r_org_lo)};
    assign ohi_ext = {4'd0, (acc ? r_org_lo : r_org_hi)};

    rexr_ram #(.WIDTH(IW), .DEPTH(MAX_REPLICAS)) u_org_ram (
        .i_clk   (i_clk),
        .i_we    (org_we),
        .i_waddr (org_waddr),
        .i_wdata (org_wdata),
        .i_raddr (org_raddr),
        .o_rdata (org_rdata)
    );

    rexr_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_REPLICAS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_lo),
        .i_wdata (cnt_next),
        .i_raddr (r_lo),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_org_vld   <= '0;
            r_cnt_vld   <= '0;
            o_res.valid <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready && !fire) begin
                o_res.valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_lo    <= i_lo;
                        r_calc  <= i_calc;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_org_lo <= r_org_vld[r_lo] ? org_rdata : r_lo;
                    r_mag_e  <= r_calc.d_energy[ENERGY_W] ? neg_e[ENERGY_W-1:0]
                                                          : r_calc.d_energy[ENERGY_W-1:0];
                    r_mag_b  <= r_calc.d_beta[BETA_W] ? neg_b[BETA_W-1:0]
                                                      : r_calc.d_beta[BETA_W-1:0];
                    r_quick  <= (r_calc.d_energy == '0) || (r_calc.d_beta == '0)
                             || (r_calc.d_energy[ENERGY_W] != r_calc.d_beta[BETA_W]);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_org_hi <= r_org_vld[hi] ? org_rdata : hi;
                    r_prod   <= {32'd0, r_mag_e} * {32'd0, r_mag_b};
                    r_state  <= S_EXP;
                end
                S_EXP: begin
                    r_big   <= |r_prod[63:50];
                    r_x     <= x_full[48:16];
                    r_cnt   <= r_cnt_vld[r_lo] ? cnt_rdata : '0;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (out_free) begin
                        o_res.valid        <= 1'b1;
                        o_res.lower_slot   <= lo_ext[3:0];
                        o_res.accepted     <= acc;
                        o_res.lower_origin <= olo_ext[3:0];
                        o_res.upper_origin <= ohi_ext[3:0];
                        o_res.accept_count <= cnt_next;
                        if (acc) begin
                            r_org_vld[r_lo] <= 1'b1;
                            r_cnt_vld[r_lo] <= 1'b1;
                            r_state         <= S_WR2;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WR2: begin
                    r_org_vld[hi] <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_wr2_after_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR2) |-> $past(r_state == S_DEC && acc))
        else $error("second origin write without an exchange");
    a_result_from_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == S_DEC))
        else $error("result raised outside the decision step");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_ABS))
        else $error("pop did not start a decision");
`endif

endmodule

// File: rtl/core/replica_exchange_round_top.sv
// replica_exchange_round_top: replica exchange metropolis decision, one result per pair
// depends on rexr_pkg, rexr_if, rexr_front, rexr_fifo, rexr_back (and rexr_ram below it)
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------------------
//  i_req   | in  | valid/ready        | energy, inv_temp, rand_u16, last_in_round
//  o_res   | out | valid/ready        | lower_slot, accepted, lower_origin,
//          |     |                    | upper_origin, accept_count
//
// steps: a request that is not the upper slot of a pair is taken without queueing; an
//   upper slot request is queued and decided by the back sequencer in S_ABS, S_MUL, S_EXP,
//   S_DEC and on an exchange S_WR2, set by the single origin read port and the two multiplies
// reset: synchronous; origin and counter memories carry per-entry valid bits,
//   so no clearing pass is needed
// stalls: a two-entry queue separates front and back; i_req.ready drops only when it is
//   full; the result register holds while o_res.ready is low and the back waits
module replica_exchange_round_top import rexr_pkg::*; #(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rexr_req_if.sink   i_req,
    rexr_res_if.source o_res
);

    localparam int IW     = $clog2(MAX_REPLICAS);
    localparam int QW     = IW + $bits(t_pair_calc);
    localparam int Q_DEPTH = 2;

    // front to queue
    logic             push;
    logic [IW-1:0]    push_lo;
    t_pair_calc       push_calc;
    logic             q_full, q_empty, pop;
    logic [QW-1:0]    q_rdata;
    logic [IW-1:0]    head_lo;
    t_pair_calc       head_calc;

    // slot counting and pair differences
    rexr_front #(.MAX_REPLICAS(MAX_REPLICAS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_full      (q_full),
        .o_push      (push),
        .o_push_lo   (push_lo),
        .o_push_calc (push_calc)
    );

    // pair requests waiting for the decision sequencer
    rexr_fifo #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({push_lo, push_calc}),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign head_lo   = q_rdata[QW-1 -: IW];
    assign head_calc = t_pair_calc'(q_rdata[$bits(t_pair_calc)-1:0]);

    // decision, table updates and result register
    rexr_back #(.MAX_REPLICAS(MAX_REPLICAS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_lo    (head_lo),
        .i_calc  (head_calc),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
